### hw/rtl/mos6502_alu_with_flags_unit_assert.svh
// Assertion helpers shared by the arithmetic unit modules.
`ifndef MOS6502_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define MOS6502_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define M6502_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define M6502_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/m6502alu_pkg.sv
package m6502alu_pkg;

  localparam int unsigned OpcodeW = 5;
  localparam int unsigned DataW   = 8;

  typedef enum logic [OpcodeW-1:0] {
    OP_LDA = 5'd0,
    OP_LDX = 5'd1,
    OP_LDY = 5'd2,
    OP_CMP = 5'd3,
    OP_CPX = 5'd4,
    OP_CPY = 5'd5,
    OP_ADC = 5'd6,
    OP_SBC = 5'd7,
    OP_ORA = 5'd8,
    OP_AND = 5'd9,
    OP_EOR = 5'd10,
    OP_BIT = 5'd11,
    OP_INC = 5'd12,
    OP_DEC = 5'd13,
    OP_ASL = 5'd14,
    OP_LSR = 5'd15,
    OP_ROL = 5'd16,
    OP_ROR = 5'd17,
    OP_INX = 5'd18,
    OP_INY = 5'd19,
    OP_DEX = 5'd20,
    OP_DEY = 5'd21
  } opcode_e;

  typedef enum logic [3:0] {
    CLS_LOAD,
    CLS_CMP,
    CLS_ADD,
    CLS_LOGIC,
    CLS_BIT,
    CLS_INCDEC,
    CLS_SHIFT,
    CLS_INDEX,
    CLS_NOP
  } op_cls_e;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_X,
    SEL_Y
  } reg_sel_e;

  typedef enum logic [1:0] {
    LOG_OR,
    LOG_AND,
    LOG_EOR
  } logic_op_e;

  typedef enum logic [1:0] {
    SH_ASL,
    SH_LSR,
    SH_ROL,
    SH_ROR
  } shift_e;

  // One classified operation as it waits between front and back.
  typedef struct packed {
    op_cls_e          cls;
    reg_sel_e         sel;
    logic             invert;
    logic             dec;
    logic_op_e        log_op;
    shift_e           shift;
    logic             on_acc;
    logic [DataW-1:0] operand;
  } uop_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctrl_t;

endpackage

### hw/rtl/m6502alu_front.sv
module m6502alu_front import m6502alu_pkg::*; (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // [7:0] operand
  input  logic [OpcodeW:0]   s_axis_tuser,   // [4:0] opcode, [5] on_accumulator
  input  logic               q_full_i,
  output logic               push_o,
  output uop_t               uop_o
);

  logic [OpcodeW-1:0] opcode;

  assign opcode        = s_axis_tuser[OpcodeW-1:0];
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    uop_o         = '0;
    uop_o.cls     = CLS_NOP;
    uop_o.sel     = SEL_A;
    uop_o.log_op  = LOG_OR;
    uop_o.shift   = SH_ASL;
    uop_o.operand = s_axis_tdata;
    uop_o.on_acc  = s_axis_tuser[OpcodeW];
    unique case (opcode)
      OP_LDA: uop_o.cls = CLS_LOAD;
      OP_LDX: begin uop_o.cls = CLS_LOAD; uop_o.sel = SEL_X; end
      OP_LDY: begin uop_o.cls = CLS_LOAD; uop_o.sel = SEL_Y; end
      OP_CMP: uop_o.cls = CLS_CMP;
      OP_CPX: begin uop_o.cls = CLS_CMP; uop_o.sel = SEL_X; end
      OP_CPY: begin uop_o.cls = CLS_CMP; uop_o.sel = SEL_Y; end
      OP_ADC: uop_o.cls = CLS_ADD;
      OP_SBC: begin uop_o.cls = CLS_ADD; uop_o.invert = 1'b1; end
      OP_ORA: uop_o.cls = CLS_LOGIC;
      OP_AND: begin uop_o.cls = CLS_LOGIC; uop_o.log_op = LOG_AND; end
      OP_EOR: begin uop_o.cls = CLS_LOGIC; uop_o.log_op = LOG_EOR; end
      OP_BIT: uop_o.cls = CLS_BIT;
      OP_INC: uop_o.cls = CLS_INCDEC;
      OP_DEC: begin uop_o.cls = CLS_INCDEC; uop_o.dec = 1'b1; end
      OP_ASL: uop_o.cls = CLS_SHIFT;
      OP_LSR: begin uop_o.cls = CLS_SHIFT; uop_o.shift = SH_LSR; end
      OP_ROL: begin uop_o.cls = CLS_SHIFT; uop_o.shift = SH_ROL; end
      OP_ROR: begin uop_o.cls = CLS_SHIFT; uop_o.shift = SH_ROR; end
      OP_INX: begin uop_o.cls = CLS_INDEX; uop_o.sel = SEL_X; end
      OP_INY: begin uop_o.cls = CLS_INDEX; uop_o.sel = SEL_Y; end
      OP_DEX: begin uop_o.cls = CLS_INDEX; uop_o.sel = SEL_X; uop_o.dec = 1'b1; end
      OP_DEY: begin uop_o.cls = CLS_INDEX; uop_o.sel = SEL_Y; uop_o.dec = 1'b1; end
      default: uop_o.cls = CLS_NOP;
    endcase
  end

endmodule

### hw/rtl/m6502alu_queue.sv
`include "mos6502_alu_with_flags_unit_assert.svh"

module m6502alu_queue import m6502alu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  uop_t uop_i,
  input  logic pop_i,
  output uop_t uop_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  uop_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign uop_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= uop_i;
    end
  end

  `M6502_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= FullCnt, "queue count beyond depth")
  `M6502_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `M6502_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, do_push && !do_pop, !empty_o, "push lost")

endmodule

### hw/rtl/m6502alu_back.sv
`include "mos6502_alu_with_flags_unit_assert.svh"

module m6502alu_back import m6502alu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  uop_t             uop_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [7:0] result
  output logic [3:0]       m_axis_tuser    // [0] N, [1] Z, [2] C, [3] V
);

  logic [DataW-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic             n_q, n_d, z_q, z_d, c_q, c_d, v_q, v_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q;
  logic [3:0]       out_flags_q;
  logic [DataW-1:0] res;

  logic [DataW-1:0] src_reg, add_b, incdec, shift_src, idx_val, log_val, shift_val;
  logic [DataW:0]   cmp_diff, add_sum;
  logic             shift_c;

  // The result register may take a new item whenever it is empty or drained.
  assign pop_o = !q_empty_i && (!out_valid_q || m_axis_tready);

  always_comb begin
    unique case (uop_i.sel)
      SEL_X:   src_reg = x_q;
      SEL_Y:   src_reg = y_q;
      default: src_reg = acc_q;
    endcase
  end

  assign cmp_diff  = {1'b0, src_reg} + {1'b0, ~uop_i.operand} + (DataW+1)'(1);
  assign add_b     = uop_i.invert ? ~uop_i.operand : uop_i.operand;
  assign add_sum   = {1'b0, acc_q} + {1'b0, add_b} + {{DataW{1'b0}}, c_q};
  assign incdec    = uop_i.dec ? uop_i.operand - DataW'(1) : uop_i.operand + DataW'(1);
  assign idx_val   = uop_i.dec ? src_reg - DataW'(1) : src_reg + DataW'(1);
  assign shift_src = uop_i.on_acc ? acc_q : uop_i.operand;

  always_comb begin
    unique case (uop_i.log_op)
      LOG_AND: log_val = acc_q & uop_i.operand;
      LOG_EOR: log_val = acc_q ^ uop_i.operand;
      default: log_val = acc_q | uop_i.operand;
    endcase
  end

  always_comb begin
    unique case (uop_i.shift)
      SH_ASL: begin
        shift_val = {shift_src[DataW-2:0], 1'b0};
        shift_c   = shift_src[DataW-1];
      end
      SH_LSR: begin
        shift_val = {1'b0, shift_src[DataW-1:1]};
        shift_c   = shift_src[0];
      end
      SH_ROL: begin
        shift_val = {shift_src[DataW-2:0], c_q};
        shift_c   = shift_src[DataW-1];
      end
      default: begin
        shift_val = {c_q, shift_src[DataW-1:1]};
        shift_c   = shift_src[0];
      end
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    n_d   = n_q;
    z_d   = z_q;
    c_d   = c_q;
    v_d   = v_q;
    res   = acc_q;
    if (pop_o) begin
      unique case (uop_i.cls)
        CLS_LOAD: begin
          res = uop_i.operand;
          unique case (uop_i.sel)
            SEL_X:   x_d   = uop_i.operand;
            SEL_Y:   y_d   = uop_i.operand;
            default: acc_d = uop_i.operand;
          endcase
        end
        CLS_CMP: begin
          res = cmp_diff[DataW-1:0];
          c_d = cmp_diff[DataW];
        end
        CLS_ADD: begin
          res   = add_sum[DataW-1:0];
          acc_d = add_sum[DataW-1:0];
          c_d   = add_sum[DataW];
          v_d   = (acc_q[DataW-1] ^ add_sum[DataW-1]) & ~(acc_q[DataW-1] ^ add_b[DataW-1]);
        end
        CLS_LOGIC: begin
          res   = log_val;
          acc_d = log_val;
        end
        CLS_BIT: begin
          res = acc_q & uop_i.operand;
          v_d = uop_i.operand[DataW-2];
        end
        CLS_INCDEC: res = incdec;
        CLS_SHIFT: begin
          res = shift_val;
          c_d = shift_c;
          if (uop_i.on_acc) begin
            acc_d = shift_val;
          end
        end
        CLS_INDEX: begin
          res = idx_val;
          if (uop_i.sel == SEL_Y) begin
            y_d = idx_val;
          end else begin
            x_d = idx_val;
          end
        end
        default: res = acc_q;
      endcase
      if (uop_i.cls != CLS_NOP) begin
        z_d = (res == '0);
        // BIT takes N from the operand rather than from the masked byte.
        n_d = (uop_i.cls == CLS_BIT) ? uop_i.operand[DataW-1] : res[DataW-1];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      n_q         <= 1'b0;
      z_q         <= 1'b0;
      c_q         <= 1'b0;
      v_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      x_q         <= x_d;
      y_q         <= y_d;
      n_q         <= n_d;
      z_q         <= z_d;
      c_q         <= c_d;
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q  <= res;
      out_flags_q <= {v_d, c_d, z_d, n_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flags_q;

  `M6502_ASSERT(a_pop_free, clk_i, rst_ni, !pop_o || !out_valid_q || m_axis_tready,
                "item taken while result register is held")
  `M6502_ASSERT_NEXT(a_pop_valid, clk_i, rst_ni, pop_o, m_axis_tvalid, "result not presented")
  `M6502_ASSERT_NEXT(a_nop_keeps_a, clk_i, rst_ni, pop_o && uop_i.cls == CLS_NOP,
                     $stable(acc_q) && $stable(c_q), "unused opcode changed state")

endmodule

### hw/rtl/mos6502_alu_with_flags_unit.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] operand; tuser[4:0] opcode, tuser[5] on_accumulator
// m_axis   | out       | tdata[7:0] result; tuser[3:0] N, Z, C, V
//
// One item per cycle is sustained while m_axis_tready is high; an accepted item is
// written into the queue, leaves it once the result register is free and is then
// presented on m_axis from that register. The rate is set by the execute stage, whose
// A, X, Y and flag registers feed straight back into the next item's add or shift.
// Reset clears A, X, Y, the flags and the queue; no clearing pass is needed.
// A stall on m_axis fills the queue, after which s_axis_tready falls.
module mos6502_alu_with_flags_unit import m6502alu_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // [7:0] operand
  input  logic [OpcodeW:0]   s_axis_tuser,   // [4:0] opcode, [5] on_accumulator
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // [7:0] result
  output logic [3:0]         m_axis_tuser    // [0] N, [1] Z, [2] C, [3] V
);

  q_ctrl_t qc;
  uop_t    front_uop, back_uop;

  m6502alu_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (qc.full),
    .push_o        (qc.push),
    .uop_o         (front_uop)
  );

  m6502alu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qc.push),
    .uop_i   (front_uop),
    .pop_i   (qc.pop),
    .uop_o   (back_uop),
    .full_o  (qc.full),
    .empty_o (qc.empty)
  );

  m6502alu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (qc.empty),
    .uop_i         (back_uop),
    .pop_o         (qc.pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
